[hw/rtl/slab_object_allocator_defines.svh]
// Assertion macros used by the slab object allocator checker.
// Depends on nothing; files that assert include it by name.
`ifndef SLAB_OBJECT_ALLOCATOR_DEFINES_SVH
`define SLAB_OBJECT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOA_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/soa_pkg.sv]
// Types and constants of the slab object allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package soa_pkg;

	localparam int ADDR_W    = 48;
	localparam int OBJ_W     = 11;
	localparam int ALIGN_W   = 13;
	localparam int STRIDE_W  = 13;
	localparam int LIVE_W    = 14;
	localparam int DIVISOR_W = 17;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POOL_BASE    = 2'd0,
		CFG_OBJECT_BYTES = 2'd1,
		CFG_ALIGNMENT    = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OOM      = 2'd1,
		STAT_BAD_ADDR = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		LST_FULL    = 2'd0,
		LST_PARTIAL = 2'd1,
		LST_EMPTY   = 2'd2
	} list_t;

	typedef enum logic [4:0] {
		BS_IDLE, BS_G0, BS_G1, BS_G2, BS_G3, BS_DISP,
		BS_TK_RD, BS_TK, BS_TK_FL, BS_ADDR1, BS_ADDR2,
		BS_F1, BS_F2, BS_F3, BS_F4, BS_WALK, BS_WALK_WT, BS_FREE,
		BS_MV_RD, BS_MV_RM, BS_MV_P1, BS_MV_P2, BS_RES
	} state_t;

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] address;
	} request_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		status_t           status;
		logic [LIVE_W-1:0] live_objects;
	} response_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] address;
	} job_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  pool_base;
		logic [OBJ_W-1:0]   object_bytes;
		logic [ALIGN_W-1:0] alignment;
	} cfg_t;

endpackage
`default_nettype wire

[hw/rtl/soa_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on soa_pkg for the divisor width.
`default_nettype none
module soa_div #(
	parameter int DW = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [DW-1:0]                 dividend,
	input  wire logic [soa_pkg::DIVISOR_W-1:0] divisor,
	output logic                               busy,
	output logic [DW-1:0]                      quotient,
	output logic [soa_pkg::DIVISOR_W-1:0]      remainder
);

	localparam int CNT_W = $clog2(DW + 1);

	logic                            busy_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [DW-1:0]                   quo_q;
	logic [soa_pkg::DIVISOR_W-1:0]   rem_q;
	logic [soa_pkg::DIVISOR_W-1:0]   dvs_q;
	logic [soa_pkg::DIVISOR_W:0]     trial;
	logic [soa_pkg::DIVISOR_W:0]     diff;
	logic                            ge;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start && !busy_q) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[soa_pkg::DIVISOR_W-1:0] : trial[soa_pkg::DIVISOR_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

[hw/rtl/soa_front.sv]
// Front end: takes requests, classifies them and holds them in a two-entry queue.
// Depends on soa_pkg for the request and job types.
`default_nettype none
module soa_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire soa_pkg::request_t request,
	output logic                   job_valid,
	output soa_pkg::job_t          job,
	input  wire logic              job_pop
);

	soa_pkg::job_t entry_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;
	soa_pkg::job_t new_job;

	always_comb begin
		do_push        = push && (cnt_q != 2'd2);
		do_pop         = job_pop && (cnt_q != 2'd0);
		new_job.op     = request.cmd ? soa_pkg::OP_FREE : soa_pkg::OP_ALLOC;
		new_job.address = request.address;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= new_job;
		end
	end

	assign full      = cnt_q == 2'd2;
	assign job_valid = cnt_q != 2'd0;
	assign job       = entry_q[rd_q];

endmodule
`default_nettype wire

[hw/rtl/soa_resq.sv]
// Two-entry result queue that parts the engine from the consumer.
// Depends on soa_pkg for the response type.
`default_nettype none
module soa_resq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire soa_pkg::response_t wr_data,
	output logic                    wr_full,
	output logic                    empty,
	input  wire logic               pop,
	output soa_pkg::response_t      response
);

	soa_pkg::response_t entry_q [2];
	logic               wr_q;
	logic               rd_q;
	logic [1:0]         cnt_q;
	logic               do_push;
	logic               do_pop;

	always_comb begin
		do_push = wr_en && (cnt_q != 2'd2);
		do_pop  = pop && (cnt_q != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= wr_data;
		end
	end

	assign wr_full  = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign response = entry_q[rd_q];

endmodule
`default_nettype wire

[hw/rtl/soa_back.sv]
// Back end: slab lists, per-slab and per-slot memories and the sequencer that runs each job.
// Depends on soa_pkg and soa_div.
`default_nettype none
module soa_back #(
	parameter int NUM_SLABS         = 16,
	parameter int PAGE_BYTES        = 4096,
	parameter int MAX_SLOTS         = 512,
	parameter int SLAB_HEADER_BYTES = 64,
	parameter int LINK_BYTES        = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire soa_pkg::cfg_t      cfg,
	input  wire logic               job_valid,
	input  wire soa_pkg::job_t      job,
	output logic                    job_pop,
	output logic                    res_valid,
	output soa_pkg::response_t      res,
	input  wire logic               res_full
);

	localparam int AW       = soa_pkg::ADDR_W;
	localparam int DW       = (AW > soa_pkg::DIVISOR_W) ? AW : soa_pkg::DIVISOR_W;
	localparam int PG_SH    = $clog2(PAGE_BYTES);
	localparam int PG_W     = AW - PG_SH;
	localparam int SLAB_W   = $clog2(NUM_SLABS + 1);
	localparam int SLAB_IW  = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
	localparam int SLOT_W   = $clog2(MAX_SLOTS + 1);
	localparam int SLOT_IW  = $clog2(MAX_SLOTS);
	localparam int STEP_W   = $clog2(MAX_SLOTS + 2);
	localparam int ROOM     = (PAGE_BYTES > SLAB_HEADER_BYTES) ?
		(PAGE_BYTES - SLAB_HEADER_BYTES) : 0;
	localparam int SLOT_DEPTH = 2 ** (SLAB_IW + SLOT_IW);
	localparam logic [SLAB_W-1:0] NIL_SLAB = SLAB_W'(NUM_SLABS);
	localparam logic [SLOT_W-1:0] NIL_SLOT = SLOT_W'(MAX_SLOTS);

	soa_pkg::state_t  state_q, state_d, ret_q;
	soa_pkg::job_t    job_q;
	soa_pkg::list_t   mv_from_q, mv_to_q;
	soa_pkg::status_t status_q;

	logic [SLAB_IW-1:0]           s_q;
	logic [SLOT_IW-1:0]           slot_q;
	logic [SLOT_W-1:0]            busy_q, freed_q, cur_q;
	logic [STEP_W-1:0]            steps_q;
	logic [SLAB_W-1:0]            oh_q;
	logic [soa_pkg::STRIDE_W-1:0] stride_q;
	logic [SLOT_W-1:0]            slots_q;
	logic [SLAB_W-1:0]            grown_q;
	logic [SLAB_W-1:0]            full_head_q, partial_head_q, empty_head_q;
	logic [soa_pkg::LIVE_W-1:0]   total_q;
	logic [AW-1:0]                prod_a_q, prod_b_q;
	logic [soa_pkg::ADDR_W-1:0]   addr_q;

	logic [SLAB_W-1:0] next_mem [NUM_SLABS];
	logic [SLAB_W-1:0] prev_mem [NUM_SLABS];
	logic [SLOT_W-1:0] busy_mem [NUM_SLABS];
	logic [SLOT_W-1:0] bump_mem [NUM_SLABS];
	logic [SLOT_W-1:0] freed_mem [NUM_SLABS];
	logic [SLOT_W-1:0] slot_mem [SLOT_DEPTH];

	logic [SLAB_W-1:0] next_rd_q, prev_rd_q;
	logic [SLOT_W-1:0] busy_rd_q, bump_rd_q, freed_rd_q, slot_rd_q;

	logic                      next_we, prev_we, busy_we, bump_we, freed_we, slot_we;
	logic [SLAB_IW-1:0]        next_wa, prev_wa, fld_wa;
	logic [SLAB_W-1:0]         next_wd, prev_wd;
	logic [SLOT_W-1:0]         busy_wd, bump_wd, freed_wd, slot_wd;
	logic [SLAB_IW+SLOT_IW-1:0] slot_a;

	logic                          div_start, div_busy;
	logic [DW-1:0]                 div_dividend, div_quo;
	logic [soa_pkg::DIVISOR_W-1:0] div_divisor, div_rem;

	logic [11:0]                   need;
	logic [soa_pkg::ALIGN_W-1:0]   al;
	logic [13:0]                   stride_calc;
	logic [AW-1:0]                 off;
	logic [SLOT_IW+soa_pkg::STRIDE_W-1:0] slot_prod;
	logic                          part_ok, emp_ok, can_grow, do_grow;
	logic                          walk_go, walk_hit;
	logic                          f1_bad, f2_bad, f4_bad;
	logic [SLAB_W-1:0]             to_head;

	soa_div #(.DW(DW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		need        = 12'(cfg.object_bytes) + 12'(LINK_BYTES);
		al          = (cfg.alignment == '0) ? soa_pkg::ALIGN_W'(1) : cfg.alignment;
		stride_calc = (div_rem == '0) ? 14'(need) :
			14'(need) - 14'(div_rem) + 14'(al);
		off         = AW'(job_q.address) - AW'(cfg.pool_base);
		slot_prod   = slot_q * stride_q;
		part_ok     = partial_head_q < NIL_SLAB;
		emp_ok      = empty_head_q < NIL_SLAB;
		can_grow    = (grown_q < NIL_SLAB) && (slots_q != '0);
		do_grow     = (state_q == soa_pkg::BS_DISP) && (job_q.op == soa_pkg::OP_ALLOC) &&
			!part_ok && !emp_ok && can_grow;
		walk_go     = (cur_q < NIL_SLOT) && (steps_q <= STEP_W'(MAX_SLOTS));
		walk_hit    = cur_q == SLOT_W'(slot_q);
		f1_bad      = off[AW-1:PG_SH] >= PG_W'(grown_q);
		f2_bad      = (div_rem != '0) || (div_quo >= DW'(slots_q));
		f4_bad      = (busy_rd_q == '0) || (SLOT_W'(slot_q) >= bump_rd_q);
		case (mv_to_q)
			soa_pkg::LST_FULL:    to_head = full_head_q;
			soa_pkg::LST_PARTIAL: to_head = partial_head_q;
			soa_pkg::LST_EMPTY:   to_head = empty_head_q;
			default:              to_head = NIL_SLAB;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			soa_pkg::BS_IDLE: begin
				if (job_valid) begin
					state_d = (grown_q == '0) ? soa_pkg::BS_G0 : soa_pkg::BS_DISP;
				end
			end
			soa_pkg::BS_G0: state_d = soa_pkg::BS_G1;
			soa_pkg::BS_G1: begin
				if (!div_busy) begin
					state_d = soa_pkg::BS_G2;
				end
			end
			soa_pkg::BS_G2: state_d = soa_pkg::BS_G3;
			soa_pkg::BS_G3: begin
				if (!div_busy) begin
					state_d = soa_pkg::BS_DISP;
				end
			end
			soa_pkg::BS_DISP: begin
				if (job_q.op == soa_pkg::OP_FREE) begin
					state_d = soa_pkg::BS_F1;
				end else if (part_ok || do_grow) begin
					state_d = soa_pkg::BS_TK_RD;
				end else if (emp_ok) begin
					state_d = soa_pkg::BS_MV_RD;
				end else begin
					state_d = soa_pkg::BS_RES;
				end
			end
			soa_pkg::BS_TK_RD: state_d = soa_pkg::BS_TK;
			soa_pkg::BS_TK: begin
				state_d = (freed_rd_q < NIL_SLOT) ? soa_pkg::BS_TK_FL : soa_pkg::BS_ADDR1;
			end
			soa_pkg::BS_TK_FL: state_d = soa_pkg::BS_ADDR1;
			soa_pkg::BS_ADDR1: state_d = soa_pkg::BS_ADDR2;
			soa_pkg::BS_ADDR2: begin
				state_d = (busy_q == slots_q) ? soa_pkg::BS_MV_RD : soa_pkg::BS_RES;
			end
			soa_pkg::BS_F1: state_d = f1_bad ? soa_pkg::BS_RES : soa_pkg::BS_F2;
			soa_pkg::BS_F2: begin
				if (!div_busy) begin
					state_d = f2_bad ? soa_pkg::BS_RES : soa_pkg::BS_F3;
				end
			end
			soa_pkg::BS_F3: state_d = soa_pkg::BS_F4;
			soa_pkg::BS_F4: state_d = f4_bad ? soa_pkg::BS_RES : soa_pkg::BS_WALK;
			soa_pkg::BS_WALK: begin
				if (!walk_go) begin
					state_d = soa_pkg::BS_FREE;
				end else if (walk_hit) begin
					state_d = soa_pkg::BS_RES;
				end else begin
					state_d = soa_pkg::BS_WALK_WT;
				end
			end
			soa_pkg::BS_WALK_WT: state_d = soa_pkg::BS_WALK;
			soa_pkg::BS_FREE: begin
				state_d = ((busy_q == slots_q) || (busy_q == SLOT_W'(1))) ?
					soa_pkg::BS_MV_RD : soa_pkg::BS_RES;
			end
			soa_pkg::BS_MV_RD: state_d = soa_pkg::BS_MV_RM;
			soa_pkg::BS_MV_RM: state_d = soa_pkg::BS_MV_P1;
			soa_pkg::BS_MV_P1: state_d = soa_pkg::BS_MV_P2;
			soa_pkg::BS_MV_P2: state_d = ret_q;
			soa_pkg::BS_RES: begin
				if (!res_full) begin
					state_d = soa_pkg::BS_IDLE;
				end
			end
			default: state_d = soa_pkg::BS_IDLE;
		endcase
	end

	always_comb begin
		job_pop      = 1'b0;
		res_valid    = 1'b0;
		div_start    = 1'b0;
		div_dividend = DW'(job_q.address);
		div_divisor  = soa_pkg::DIVISOR_W'(stride_q);
		next_we      = 1'b0;
		next_wa      = s_q;
		next_wd      = NIL_SLAB;
		prev_we      = 1'b0;
		prev_wa      = s_q;
		prev_wd      = NIL_SLAB;
		fld_wa       = s_q;
		busy_we      = 1'b0;
		busy_wd      = busy_rd_q + SLOT_W'(1);
		bump_we      = 1'b0;
		bump_wd      = bump_rd_q + SLOT_W'(1);
		freed_we     = 1'b0;
		freed_wd     = slot_rd_q;
		slot_we      = 1'b0;
		slot_wd      = freed_q;
		slot_a       = {s_q, slot_q};
		case (state_q)
			soa_pkg::BS_IDLE: job_pop = job_valid;
			soa_pkg::BS_G0: begin
				div_start    = 1'b1;
				div_dividend = DW'(need);
				div_divisor  = soa_pkg::DIVISOR_W'(al);
			end
			soa_pkg::BS_G2: begin
				div_start    = 1'b1;
				div_dividend = DW'(ROOM);
			end
			soa_pkg::BS_DISP: begin
				if (do_grow) begin
					next_we  = 1'b1;
					next_wa  = SLAB_IW'(grown_q);
					prev_we  = 1'b1;
					prev_wa  = SLAB_IW'(grown_q);
					fld_wa   = SLAB_IW'(grown_q);
					busy_we  = 1'b1;
					busy_wd  = '0;
					bump_we  = 1'b1;
					bump_wd  = '0;
					freed_we = 1'b1;
					freed_wd = NIL_SLOT;
				end
			end
			soa_pkg::BS_TK: begin
				busy_we = 1'b1;
				slot_a  = {s_q, freed_rd_q[SLOT_IW-1:0]};
				if (freed_rd_q >= NIL_SLOT) begin
					bump_we = 1'b1;
				end
			end
			soa_pkg::BS_TK_FL: freed_we = 1'b1;
			soa_pkg::BS_F1: begin
				if (!f1_bad) begin
					div_start    = 1'b1;
					div_dividend = DW'(off[PG_SH-1:0]);
				end
			end
			soa_pkg::BS_WALK: slot_a = {s_q, cur_q[SLOT_IW-1:0]};
			soa_pkg::BS_FREE: begin
				slot_we  = 1'b1;
				freed_we = 1'b1;
				freed_wd = SLOT_W'(slot_q);
				busy_we  = 1'b1;
				busy_wd  = busy_q - SLOT_W'(1);
			end
			soa_pkg::BS_MV_RM: begin
				if (prev_rd_q < NIL_SLAB) begin
					next_we = 1'b1;
					next_wa = SLAB_IW'(prev_rd_q);
					next_wd = next_rd_q;
				end
				if (next_rd_q < NIL_SLAB) begin
					prev_we = 1'b1;
					prev_wa = SLAB_IW'(next_rd_q);
					prev_wd = prev_rd_q;
				end
			end
			soa_pkg::BS_MV_P1: begin
				prev_we = 1'b1;
				next_we = 1'b1;
				next_wd = to_head;
			end
			soa_pkg::BS_MV_P2: begin
				if (oh_q < NIL_SLAB) begin
					prev_we = 1'b1;
					prev_wa = SLAB_IW'(oh_q);
					prev_wd = SLAB_W'(s_q);
				end
			end
			soa_pkg::BS_RES: res_valid = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (busy_we) begin
			busy_mem[fld_wa] <= busy_wd;
		end
		if (bump_we) begin
			bump_mem[fld_wa] <= bump_wd;
		end
		if (freed_we) begin
			freed_mem[fld_wa] <= freed_wd;
		end
		if (slot_we) begin
			slot_mem[slot_a] <= slot_wd;
		end
		next_rd_q  <= next_mem[s_q];
		prev_rd_q  <= prev_mem[s_q];
		busy_rd_q  <= busy_mem[s_q];
		bump_rd_q  <= bump_mem[s_q];
		freed_rd_q <= freed_mem[s_q];
		slot_rd_q  <= slot_mem[slot_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= soa_pkg::BS_IDLE;
			grown_q        <= '0;
			full_head_q    <= NIL_SLAB;
			partial_head_q <= NIL_SLAB;
			empty_head_q   <= NIL_SLAB;
			total_q        <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				soa_pkg::BS_DISP: begin
					if (do_grow) begin
						grown_q        <= grown_q + SLAB_W'(1);
						partial_head_q <= grown_q;
					end
				end
				soa_pkg::BS_TK: total_q <= total_q + soa_pkg::LIVE_W'(1);
				soa_pkg::BS_FREE: total_q <= total_q - soa_pkg::LIVE_W'(1);
				soa_pkg::BS_MV_RM: begin
					if (prev_rd_q >= NIL_SLAB) begin
						case (mv_from_q)
							soa_pkg::LST_FULL:    full_head_q    <= next_rd_q;
							soa_pkg::LST_PARTIAL: partial_head_q <= next_rd_q;
							soa_pkg::LST_EMPTY:   empty_head_q   <= next_rd_q;
							default: begin
							end
						endcase
					end
				end
				soa_pkg::BS_MV_P1: begin
					case (mv_to_q)
						soa_pkg::LST_FULL:    full_head_q    <= SLAB_W'(s_q);
						soa_pkg::LST_PARTIAL: partial_head_q <= SLAB_W'(s_q);
						soa_pkg::LST_EMPTY:   empty_head_q   <= SLAB_W'(s_q);
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			soa_pkg::BS_IDLE: begin
				if (job_valid) begin
					job_q <= job;
				end
			end
			soa_pkg::BS_G1: begin
				if (!div_busy) begin
					stride_q <= stride_calc[soa_pkg::STRIDE_W-1:0];
				end
			end
			soa_pkg::BS_G3: begin
				if (!div_busy) begin
					slots_q <= (div_quo > DW'(MAX_SLOTS)) ? NIL_SLOT : SLOT_W'(div_quo);
				end
			end
			soa_pkg::BS_DISP: begin
				mv_from_q <= soa_pkg::LST_EMPTY;
				mv_to_q   <= soa_pkg::LST_PARTIAL;
				ret_q     <= soa_pkg::BS_TK_RD;
				if (part_ok) begin
					s_q <= SLAB_IW'(partial_head_q);
				end else if (emp_ok) begin
					s_q <= SLAB_IW'(empty_head_q);
				end else begin
					s_q <= SLAB_IW'(grown_q);
				end
				status_q <= soa_pkg::STAT_OOM;
				addr_q   <= '0;
			end
			soa_pkg::BS_TK: begin
				busy_q <= busy_rd_q + SLOT_W'(1);
				slot_q <= (freed_rd_q < NIL_SLOT) ? freed_rd_q[SLOT_IW-1:0] :
					bump_rd_q[SLOT_IW-1:0];
			end
			soa_pkg::BS_ADDR1: begin
				prod_a_q <= AW'(s_q) << PG_SH;
				prod_b_q <= AW'(slot_prod);
			end
			soa_pkg::BS_ADDR2: begin
				addr_q    <= soa_pkg::ADDR_W'(AW'(cfg.pool_base) + prod_a_q + prod_b_q);
				status_q  <= soa_pkg::STAT_OK;
				mv_from_q <= soa_pkg::LST_PARTIAL;
				mv_to_q   <= soa_pkg::LST_FULL;
				ret_q     <= soa_pkg::BS_RES;
			end
			soa_pkg::BS_F1: begin
				s_q      <= SLAB_IW'(off[AW-1:PG_SH]);
				status_q <= soa_pkg::STAT_BAD_ADDR;
				addr_q   <= '0;
			end
			soa_pkg::BS_F2: slot_q <= SLOT_IW'(div_quo);
			soa_pkg::BS_F4: begin
				busy_q  <= busy_rd_q;
				freed_q <= freed_rd_q;
				cur_q   <= freed_rd_q;
				steps_q <= '0;
			end
			soa_pkg::BS_WALK: begin
				if (walk_go) begin
					steps_q <= steps_q + STEP_W'(1);
				end
			end
			soa_pkg::BS_WALK_WT: cur_q <= slot_rd_q;
			soa_pkg::BS_FREE: begin
				status_q <= soa_pkg::STAT_OK;
				ret_q    <= soa_pkg::BS_RES;
				if (busy_q == slots_q) begin
					mv_from_q <= soa_pkg::LST_FULL;
					mv_to_q   <= soa_pkg::LST_PARTIAL;
				end else begin
					mv_from_q <= soa_pkg::LST_PARTIAL;
					mv_to_q   <= soa_pkg::LST_EMPTY;
				end
			end
			soa_pkg::BS_MV_P1: oh_q <= to_head;
			default: begin
			end
		endcase
	end

	always_comb begin
		res.result_address = addr_q;
		res.status         = status_q;
		res.live_objects   = total_q;
	end

endmodule
`default_nettype wire

[hw/rtl/slab_object_allocator.sv]
// Top level of the slab object allocator: configuration registers, front, back and result queue.
// Depends on soa_pkg, soa_front, soa_back and soa_resq.
// Each item is handled alone by a sequencer in the back end. An allocate from a slab already on
// the partial list runs the take and address states, with an extra take state when it reuses a
// freed slot, and each move of a slab between lists adds the move states. An allocate that finds
// no slab goes straight to the result. A free finds its slab with a shift and then takes one pass
// of the bit-serial divider for the slot index, then walks that slab's freed list to reject a
// double free, and moves the slab when it changes lists; an address outside the grown slabs is
// rejected before the divider starts. While no slab has been grown, each item first recomputes
// the slot geometry with two divider passes. A full result queue holds the back end in its
// result state. Requests and results are each buffered two deep.
`default_nettype none
module slab_object_allocator #(
	parameter int NUM_SLABS         = 16,
	parameter int PAGE_BYTES        = 4096,
	parameter int MAX_SLOTS         = 512,
	parameter int SLAB_HEADER_BYTES = 64,
	parameter int LINK_BYTES        = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire soa_pkg::request_t              request,
	output logic                                empty,
	input  wire logic                           pop,
	output soa_pkg::response_t                  response,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [soa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [soa_pkg::ADDR_W-1:0]     cfg_data
);

	soa_pkg::cfg_t      cfg_q;
	logic               job_valid;
	soa_pkg::job_t      job;
	logic               job_pop;
	logic               res_valid;
	soa_pkg::response_t res;
	logic               res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pool_base    <= '0;
			cfg_q.object_bytes <= soa_pkg::OBJ_W'(64);
			cfg_q.alignment    <= soa_pkg::ALIGN_W'(8);
		end else if (cfg_valid) begin
			case (cfg_index)
				soa_pkg::CFG_POOL_BASE:    cfg_q.pool_base    <= cfg_data;
				soa_pkg::CFG_OBJECT_BYTES: cfg_q.object_bytes <= cfg_data[soa_pkg::OBJ_W-1:0];
				soa_pkg::CFG_ALIGNMENT:    cfg_q.alignment    <= cfg_data[soa_pkg::ALIGN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	soa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	soa_back #(
		.NUM_SLABS         (NUM_SLABS),
		.PAGE_BYTES        (PAGE_BYTES),
		.MAX_SLOTS         (MAX_SLOTS),
		.SLAB_HEADER_BYTES (SLAB_HEADER_BYTES),
		.LINK_BYTES        (LINK_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_full  (res_full)
	);

	soa_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_valid),
		.wr_data  (res),
		.wr_full  (res_full),
		.empty    (empty),
		.pop      (pop),
		.response (response)
	);

endmodule
`default_nettype wire

[hw/rtl/soa_checker.sv]
// Port-level checks on the result side of the slab object allocator, bound to the top level.
// Depends on soa_pkg and slab_object_allocator_defines.svh.
`default_nettype none
`include "slab_object_allocator_defines.svh"
module soa_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               empty,
	input wire logic               pop,
	input wire soa_pkg::response_t response
);

	`SOA_ASSERT_NEXT(a_res_hold, clk, arst_n, !empty && !pop, !empty && $stable(response), "Waiting item changed before it was taken.")
	`SOA_ASSERT_IMPLY(a_err_zero, clk, arst_n, !empty && response.status != soa_pkg::STAT_OK, response.result_address == '0, "Failed item carries an address.")
	`SOA_ASSERT_IMPLY(a_alloc_live, clk, arst_n, !empty && response.status == soa_pkg::STAT_OK && response.result_address != '0, response.live_objects != '0, "Allocation leaves no live object.")

endmodule

bind slab_object_allocator soa_checker u_soa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.response (response)
);
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the slab object allocator: directed and random alloc/free items,
// checked against a behavioral predictor of the slab lists, slot free lists and live count.
// Depends on soa_pkg and slab_object_allocator.
`default_nettype none
module tb_top;

	localparam int NSLAB = 16;
	localparam int NSLOT = 512;
	localparam int ROOM = 4096 - 64;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic push, full, empty, pop;
	soa_pkg::request_t request;
	soa_pkg::response_t response;
	logic cfg_valid, cfg_ready;
	logic [soa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [soa_pkg::ADDR_W-1:0] cfg_data;

	slab_object_allocator u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .request(request),
		.empty(empty), .pop(pop), .response(response), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [47:0] pool_base_q;
	int unsigned obj_bytes_q, align_q, stride, spp, grown, total;
	int unsigned head[3];
	int unsigned nxt[NSLAB], prv[NSLAB], busy[NSLAB], bump[NSLAB], fhead[NSLAB];
	int unsigned snext[NSLAB*NSLOT];

	soa_pkg::response_t expected_q[$];
	logic [47:0] live_offs[$];
	logic [47:0] freed_offs[$];
	int mismatches = 0;
	int burst_left = 0;
	int pop_mode = 0, pop_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400_000_000;
		$display("slab_object_allocator regression: fail");
		$finish;
	end

	function automatic void recompute();
		int unsigned al, n;
		al = (align_q != 0) ? align_q : 1;
		stride = ((obj_bytes_q + 8 + al - 1) / al) * al;
		n = ROOM / stride;
		spp = (n > NSLOT) ? NSLOT : n;
	endfunction

	function automatic void lst_remove(soa_pkg::list_t l, int unsigned s);
		int unsigned p, n;
		p = prv[s];
		n = nxt[s];
		if (p >= NSLAB) head[l] = n;
		else nxt[p] = n;
		if (n < NSLAB) prv[n] = p;
	endfunction

	function automatic void lst_push(soa_pkg::list_t l, int unsigned s);
		prv[s] = NSLAB;
		nxt[s] = head[l];
		if (head[l] < NSLAB) prv[head[l]] = s;
		head[l] = s;
	endfunction

	function automatic bit slot_free(int unsigned s, int unsigned slot);
		int unsigned cur, steps;
		cur = fhead[s];
		steps = 0;
		if (slot >= bump[s]) return 1'b1;
		while (cur < NSLOT && steps <= NSLOT) begin
			if (cur == slot) return 1'b1;
			cur = snext[s*NSLOT + cur];
			steps++;
		end
		return 1'b0;
	endfunction

	function automatic soa_pkg::response_t model_alloc();
		soa_pkg::response_t r;
		int unsigned s, slot;
		r = '0;
		if (head[soa_pkg::LST_PARTIAL] >= NSLAB) begin
			if (head[soa_pkg::LST_EMPTY] >= NSLAB) begin
				if (grown >= NSLAB || spp == 0) begin
					r.status = soa_pkg::STAT_OOM;
					r.live_objects = total;
					return r;
				end
				s = grown++;
				busy[s] = 0;
				bump[s] = 0;
				fhead[s] = NSLOT;
				lst_push(soa_pkg::LST_EMPTY, s);
			end
			s = head[soa_pkg::LST_EMPTY];
			lst_remove(soa_pkg::LST_EMPTY, s);
			lst_push(soa_pkg::LST_PARTIAL, s);
		end
		s = head[soa_pkg::LST_PARTIAL];
		if (fhead[s] < NSLOT) begin
			slot = fhead[s];
			fhead[s] = snext[s*NSLOT + slot];
		end else begin
			slot = bump[s]++;
		end
		busy[s]++;
		if (busy[s] == spp) begin
			lst_remove(soa_pkg::LST_PARTIAL, s);
			lst_push(soa_pkg::LST_FULL, s);
		end
		total++;
		r.result_address = pool_base_q + 48'(s) * 48'd4096 + 48'(slot * stride);
		r.status = soa_pkg::STAT_OK;
		r.live_objects = total;
		return r;
	endfunction

	function automatic soa_pkg::response_t model_free(logic [47:0] a);
		soa_pkg::response_t r;
		logic [47:0] off;
		longint unsigned s64, page_off;
		int unsigned s, slot;
		r = '0;
		r.status = soa_pkg::STAT_BAD_ADDR;
		off = a - pool_base_q;
		s64 = off / 4096;
		page_off = off % 4096;
		if (s64 < grown && page_off % stride == 0 && page_off / stride < spp) begin
			s = 32'(s64);
			slot = 32'(page_off / stride);
			if (busy[s] != 0 && !slot_free(s, slot)) begin
				snext[s*NSLOT + slot] = fhead[s];
				fhead[s] = slot;
				busy[s]--;
				total--;
				if (busy[s] + 1 == spp) begin
					lst_remove(soa_pkg::LST_FULL, s);
					lst_push(soa_pkg::LST_PARTIAL, s);
				end else if (busy[s] == 0) begin
					lst_remove(soa_pkg::LST_PARTIAL, s);
					lst_push(soa_pkg::LST_EMPTY, s);
				end
				r.status = soa_pkg::STAT_OK;
			end
		end
		r.live_objects = total;
		return r;
	endfunction

	task automatic send_item(soa_pkg::op_t op, logic [47:0] a);
		soa_pkg::response_t r;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
		end else begin
			burst_left--;
		end
		request <= '{cmd: op, address: a};
		push <= 1'b1;
		do @(posedge clk); while (full);
		r = (op == soa_pkg::OP_ALLOC) ? model_alloc() : model_free(a);
		expected_q.push_back(r);
		if (r.status == soa_pkg::STAT_OK && op == soa_pkg::OP_ALLOC)
			live_offs.push_back(r.result_address - pool_base_q);
		if (r.status == soa_pkg::STAT_OK && op == soa_pkg::OP_FREE) begin
			freed_offs.push_back(a - pool_base_q);
			if (freed_offs.size() > 8) void'(freed_offs.pop_front());
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		burst_left = 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [soa_pkg::CFG_IDX_W-1:0] idx, logic [47:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == soa_pkg::CFG_POOL_BASE) pool_base_q = d;
		else if (idx == soa_pkg::CFG_OBJECT_BYTES) obj_bytes_q = d[10:0];
		else if (idx == soa_pkg::CFG_ALIGNMENT) align_q = d[12:0];
		if (idx != CFG_UNUSED && grown == 0) recompute();
		@(posedge clk);
	endtask

	task automatic free_live();
		int i;
		logic [47:0] off;
		i = $urandom_range(0, live_offs.size() - 1);
		off = live_offs[i];
		live_offs.delete(i);
		send_item(soa_pkg::OP_FREE, pool_base_q + off);
	endtask

	task automatic run_mix(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (live_offs.size() == 0 || r < 52) begin
				send_item(soa_pkg::OP_ALLOC, 48'({$urandom, $urandom} >> 16));
			end else if (r < 85) begin
				free_live();
			end else if (r < 91 && freed_offs.size() != 0) begin
				send_item(soa_pkg::OP_FREE,
					pool_base_q + freed_offs[$urandom_range(0, freed_offs.size() - 1)]);
			end else if (r < 96) begin
				send_item(soa_pkg::OP_FREE,
					pool_base_q + 48'($urandom_range(0, (grown + 1) * 4096 - 1)));
			end else begin
				send_item(soa_pkg::OP_FREE, 48'({$urandom, $urandom} >> 16));
			end
		end
	endtask

	// Geometry is only recomputed while no slab exists, so all sizing checks come first.
	task automatic test_geometry();
		write_reg(CFG_UNUSED, 48'({$urandom, $urandom} >> 16));
		write_reg(soa_pkg::CFG_ALIGNMENT, 48'd4096);
		write_reg(soa_pkg::CFG_OBJECT_BYTES, 48'd1024);
		send_item(soa_pkg::OP_ALLOC, '1);
		drain();
		write_reg(soa_pkg::CFG_ALIGNMENT, 48'h1FFF);
		send_item(soa_pkg::OP_ALLOC, '0);
		drain();
		write_reg(soa_pkg::CFG_ALIGNMENT, 48'({$urandom, $urandom} >> 16));
		send_item(soa_pkg::OP_FREE, '0);
		drain();
		case ($urandom_range(0, 4))
			0: begin
				write_reg(soa_pkg::CFG_OBJECT_BYTES, 48'd1024);
				write_reg(soa_pkg::CFG_ALIGNMENT, 48'd2048);
			end
			1: begin
				write_reg(soa_pkg::CFG_OBJECT_BYTES, 48'd1000);
				write_reg(soa_pkg::CFG_ALIGNMENT, 48'd8);
			end
			2: begin
				write_reg(soa_pkg::CFG_OBJECT_BYTES, 48'd1);
				write_reg(soa_pkg::CFG_ALIGNMENT, 48'd0);
			end
			3: begin
				write_reg(soa_pkg::CFG_OBJECT_BYTES, 48'd200);
				write_reg(soa_pkg::CFG_ALIGNMENT, 48'd64);
			end
			default: begin
				write_reg(soa_pkg::CFG_OBJECT_BYTES, 48'd64);
				write_reg(soa_pkg::CFG_ALIGNMENT, 48'd1);
			end
		endcase
		write_reg(soa_pkg::CFG_POOL_BASE, 48'd0);
	endtask

	task automatic test_directed();
		repeat (5) send_item(soa_pkg::OP_ALLOC, '1);
		free_live();
		free_live();
		send_item(soa_pkg::OP_FREE, pool_base_q + freed_offs[freed_offs.size() - 1]);
		send_item(soa_pkg::OP_FREE, pool_base_q + 48'd1);
		send_item(soa_pkg::OP_FREE, pool_base_q + 48'(spp * stride));
		send_item(soa_pkg::OP_FREE, pool_base_q + 48'(grown * 4096));
		send_item(soa_pkg::OP_FREE, '1);
		send_item(soa_pkg::OP_FREE, '0);
		repeat (3) send_item(soa_pkg::OP_ALLOC, '0);
		while (live_offs.size() != 0) free_live();
		send_item(soa_pkg::OP_ALLOC, '0);
		drain();
	endtask

	// Moving the pool applies to every address; size writes now leave the geometry alone.
	task automatic test_pool_move();
		write_reg(soa_pkg::CFG_POOL_BASE, 48'hFFFF_FFFF_F000);
		write_reg(soa_pkg::CFG_OBJECT_BYTES, 48'd1024);
		write_reg(soa_pkg::CFG_ALIGNMENT, 48'd4096);
		run_mix(170);
		drain();
		write_reg(soa_pkg::CFG_POOL_BASE, 48'({$urandom, $urandom} >> 16));
		write_reg(soa_pkg::CFG_OBJECT_BYTES, 48'd1);
		run_mix(170);
		drain();
	endtask

	task automatic test_churn();
		run_mix(1300);
		drain();
	endtask

	always @(posedge clk) begin
		soa_pkg::response_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", response);
				end else begin
					e = expected_q.pop_front();
					if (e.result_address !== response.result_address || e.status !== response.status
							|| e.live_objects !== response.live_objects) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected addr %h status %0d live %0d, got addr %h status %0d live %0d",
								e.result_address, e.status, e.live_objects,
								response.result_address, response.status, response.live_objects);
					end
				end
			end
			if (pop_left == 0) begin
				pop_mode = $urandom_range(0, 2);
				pop_left = $urandom_range(10, 300);
			end else begin
				pop_left--;
			end
			case (pop_mode)
				0: pop <= 1'b1;
				1: pop <= $urandom_range(0, 1);
				default: pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin
		push = 1'b0;
		pop = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		pool_base_q = '0;
		obj_bytes_q = 64;
		align_q = 8;
		grown = 0;
		total = 0;
		head = '{NSLAB, NSLAB, NSLAB};
		recompute();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_geometry();
		test_directed();
		test_churn();
		test_pool_move();
		if (mismatches == 0) $display("slab_object_allocator regression: pass");
		else $display("slab_object_allocator regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
